### rtl/core/tpdf_pkg.sv
package tpdf_pkg;

  // Field widths
  localparam int CH_W      = 4;
  localparam int TIME_W    = 53;
  localparam int RATE_W    = 10;
  localparam int CNT_W     = 16;
  localparam int REG_W     = 40;
  localparam int VERDICT_W = 4;
  localparam int TOL_W     = 14;
  localparam int CFG_IDX_W = 1;

  // Default geometry
  localparam int DEF_NUM_CHANNELS = 16;
  localparam int DEF_RING_DEPTH   = 64;

  // Register reset values
  localparam logic [REG_W-1:0] MAX_FUTURE_RST  = '0;
  localparam logic [REG_W-1:0] MAX_LATENCY_RST = 40'd500000000;

  // Rate bands and their start tolerances in microseconds
  localparam logic [RATE_W-1:0] RATE_BAND_LOW  = 10'd105;
  localparam logic [RATE_W-1:0] RATE_BAND_MID  = 10'd255;
  localparam logic [RATE_W-1:0] RATE_BAND_HIGH = 10'd505;
  localparam logic [RATE_W-1:0] RATE_BAND_TOP  = 10'd1005;
  localparam logic [TOL_W-1:0]  TOL_LOW        = 14'd15000;
  localparam logic [TOL_W-1:0]  TOL_MID        = 14'd4500;
  localparam logic [TOL_W-1:0]  TOL_HIGH       = 14'd2500;
  localparam logic [TOL_W-1:0]  TOL_TOP        = 14'd1500;

  typedef enum logic [VERDICT_W-1:0] {
    V_APPENDED      = 4'd0,
    V_BACKFILLED    = 4'd1,
    V_EMPTY         = 4'd2,
    V_EXPIRED       = 4'd3,
    V_FUTURE        = 4'd4,
    V_DUPLICATE     = 4'd5,
    V_SLIP          = 4'd6,
    V_RATE_MISMATCH = 4'd7,
    V_BAD_RATE      = 4'd8
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FUTURE  = 1'b0,
    REG_MAX_LATENCY = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MOVE,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] stop_time;
    logic [RATE_W-1:0] rate;
  } entry_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [RATE_W-1:0] sample_rate;
    logic [CNT_W-1:0]  sample_count;
    logic [TIME_W-1:0] now_time;
  } pkt_t;

  typedef struct packed {
    logic     allowed;
    verdict_e verdict;
  } result_t;

  // Start tolerance for a rate, zero when the rate falls outside every band
  function automatic logic [TOL_W-1:0] tolerance_for(input logic [RATE_W-1:0] rate);
    logic [TOL_W-1:0] tol;
    priority if (rate < RATE_BAND_LOW)  tol = TOL_LOW;
    else if (rate < RATE_BAND_MID)      tol = TOL_MID;
    else if (rate < RATE_BAND_HIGH)     tol = TOL_HIGH;
    else if (rate < RATE_BAND_TOP)      tol = TOL_TOP;
    else                                tol = '0;
    return tol;
  endfunction

endpackage

### rtl/core/tpdf_if.sv
interface tpdf_pkt_if import tpdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [RATE_W-1:0] sample_rate;
  logic [CNT_W-1:0]  sample_count;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, channel, start_time, end_time, sample_rate, sample_count,
                  now_time, input ready);
  modport sink (input valid, channel, start_time, end_time, sample_rate, sample_count,
                now_time, output ready);
endinterface

interface tpdf_res_if import tpdf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 allowed;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, allowed, verdict, input ready);
  modport sink (input valid, allowed, verdict, output ready);
endinterface

interface tpdf_cfg_if import tpdf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/tpdf_mem.sv
module tpdf_mem import tpdf_pkg::*; #(
  parameter int DEPTH  = DEF_NUM_CHANNELS * DEF_RING_DEPTH,
  parameter int ADDR_W = $clog2(DEF_NUM_CHANNELS * DEF_RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  entry_t            wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output entry_t            rdata_o
);

  entry_t mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/tpdf_seq.sv
module tpdf_seq import tpdf_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int RING_DEPTH   = DEF_RING_DEPTH,
  parameter int ADDR_W       = $clog2(DEF_NUM_CHANNELS * DEF_RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pkt_valid_i,
  input  pkt_t              pkt_i,
  output logic              pkt_ready_o,
  input  logic [REG_W-1:0]  max_future_i,
  input  logic [REG_W-1:0]  max_latency_i,
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_ready_i,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output entry_t            mem_wdata_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  entry_t            mem_rdata_i
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CHI_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  seq_state_e        state_q, state_d;
  pkt_t              pkt_q, pkt_d;
  logic [CHI_W-1:0]  ch_q, ch_d, ch_mod;
  logic [FILL_W-1:0] n_q, n_d;
  logic [FILL_W-1:0] idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [FILL_W-1:0] pend_idx_q, pend_idx_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic              slip_q, slip_d;
  logic [FILL_W-1:0] left_q, left_d;
  logic              up_q, up_d;
  logic [FILL_W-1:0] wpos_q, wpos_d;
  verdict_e          verdict_q, verdict_d;
  logic [FILL_W-1:0] fill_q [NUM_CHANNELS];
  logic [FILL_W-1:0] fill_d [NUM_CHANNELS];

  logic [ADDR_W-1:0] base;
  logic [TOL_W-1:0]  tol;
  logic [TIME_W-1:0] diff;
  logic              dup, before_st, overlap, expired, future, full;
  logic [FILL_W-1:0] pos_n, n_cur;
  logic              slip_n;
  entry_t            new_entry;

  // Fold the channel onto the configured channel count
  always_comb begin
    ch_mod = '0;
    for (int k = 0; k < (1 << CH_W); k++) begin
      if (pkt_i.channel == CH_W'(k)) ch_mod = CHI_W'(k % NUM_CHANNELS);
    end
  end

  assign base  = ADDR_W'(ch_q * RING_DEPTH);
  assign tol   = tolerance_for(pkt_q.sample_rate);
  assign n_cur = fill_q[ch_q];
  assign full  = (n_q == FILL_W'(RING_DEPTH));

  assign new_entry.start_time = pkt_q.start_time;
  assign new_entry.stop_time  = pkt_q.end_time;
  assign new_entry.rate       = pkt_q.sample_rate;

  // Window tests against the current time
  assign expired = ({1'b0, pkt_q.end_time} + (TIME_W + 1)'(max_latency_i))
                   < {1'b0, pkt_q.now_time};
  assign future  = {1'b0, pkt_q.end_time}
                   > ({1'b0, pkt_q.now_time} + (TIME_W + 1)'(max_future_i));

  // Compare the stored entry that has just been read
  assign diff      = (pkt_q.start_time >= mem_rdata_i.start_time)
                     ? pkt_q.start_time - mem_rdata_i.start_time
                     : mem_rdata_i.start_time - pkt_q.start_time;
  assign dup       = diff < TIME_W'(tol);
  assign before_st = mem_rdata_i.start_time < pkt_q.start_time;
  assign overlap   = (pkt_q.start_time >= mem_rdata_i.start_time &&
                      pkt_q.start_time <= mem_rdata_i.stop_time) ||
                     (pkt_q.end_time >= mem_rdata_i.start_time &&
                      pkt_q.end_time <= mem_rdata_i.stop_time);
  assign pos_n     = pos_q + FILL_W'(before_st);
  assign slip_n    = slip_q | overlap;

  // Sequencer: check, scan the ring, shift, write the new entry
  always_comb begin
    state_d    = state_q;
    pkt_d      = pkt_q;
    ch_d       = ch_q;
    n_d        = n_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pos_d      = pos_q;
    slip_d     = slip_q;
    left_d     = left_q;
    up_d       = up_q;
    wpos_d     = wpos_q;
    verdict_d  = verdict_q;
    fill_d     = fill_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = base;
    mem_wdata_o = new_entry;
    mem_raddr_o = base + ADDR_W'(idx_q[IDX_W-1:0]);
    pkt_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);

    unique case (state_q)
      S_IDLE: begin
        if (pkt_valid_i) begin
          pkt_d   = pkt_i;
          ch_d    = ch_mod;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        n_d    = n_cur;
        idx_d  = '0;
        pend_d = 1'b0;
        pos_d  = '0;
        slip_d = 1'b0;
        priority if (pkt_q.sample_count == '0) begin
          verdict_d = V_EMPTY;
          state_d   = S_DONE;
        end else if (expired) begin
          verdict_d = V_EXPIRED;
          state_d   = S_DONE;
        end else if (future) begin
          verdict_d = V_FUTURE;
          state_d   = S_DONE;
        end else if (n_cur == '0) begin
          if (tol == '0) begin
            verdict_d = V_BAD_RATE;
          end else begin
            mem_we_o     = 1'b1;
            fill_d[ch_q] = FILL_W'(1);
            verdict_d    = V_APPENDED;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        pend_d = (idx_q < n_q);
        if (idx_q < n_q) idx_d = idx_q + FILL_W'(1);
        if (pend_q) begin
          priority if (mem_rdata_i.rate != pkt_q.sample_rate) begin
            verdict_d = V_RATE_MISMATCH;
            state_d   = S_DONE;
          end else if (tol == '0) begin
            verdict_d = V_BAD_RATE;
            state_d   = S_DONE;
          end else if (dup) begin
            verdict_d = V_DUPLICATE;
            state_d   = S_DONE;
          end else begin
            pos_d  = pos_n;
            slip_d = slip_n;
            if (idx_q == n_q) begin
              if (pos_n != n_q && slip_n) begin
                verdict_d = V_SLIP;
                state_d   = S_DONE;
              end else begin
                verdict_d = (pos_n == n_q) ? V_APPENDED : V_BACKFILLED;
                pend_d    = 1'b0;
                state_d   = S_MOVE;
                if (full) begin
                  // evict the oldest: slide the lower part down by one
                  up_d   = 1'b0;
                  idx_d  = FILL_W'(1);
                  left_d = (pos_n == '0) ? '0 : pos_n - FILL_W'(1);
                  wpos_d = (pos_n == '0) ? '0 : pos_n - FILL_W'(1);
                end else begin
                  // open a gap: slide the upper part up by one
                  up_d   = 1'b1;
                  idx_d  = n_q - FILL_W'(1);
                  left_d = n_q - pos_n;
                  wpos_d = pos_n;
                end
              end
            end
          end
        end
      end

      S_MOVE: begin
        pend_d = (left_q != '0);
        if (left_q != '0) begin
          idx_d      = up_q ? idx_q - FILL_W'(1) : idx_q + FILL_W'(1);
          left_d     = left_q - FILL_W'(1);
          pend_idx_d = idx_q;
        end
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          mem_waddr_o = base + ADDR_W'(up_q ? (pend_idx_q + FILL_W'(1)) :
                                              (pend_idx_q - FILL_W'(1)));
        end else if (left_q == '0) begin
          mem_we_o     = 1'b1;
          mem_waddr_o  = base + ADDR_W'(wpos_q[IDX_W-1:0]);
          fill_d[ch_q] = up_q ? n_q + FILL_W'(1) : n_q;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.allowed = (verdict_q == V_APPENDED) || (verdict_q == V_BACKFILLED);
  assign res_o.verdict = verdict_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) fill_q[c] <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      fill_q  <= fill_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pkt_q      <= pkt_d;
    ch_q       <= ch_d;
    n_q        <= n_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    pos_q      <= pos_d;
    slip_q     <= slip_d;
    left_q     <= left_d;
    up_q       <= up_d;
    wpos_q     <= wpos_d;
    verdict_q  <= verdict_d;
  end

endmodule

### rtl/core/timestamped_packet_dedup_filter.sv
// Packet header duplicate filter.
// pkt_i carries one header per beat (channel, start, end, rate, sample count,
// current time); res_o returns one verdict beat (allowed, verdict) per header.
// cfg_i writes max_future_us (index 0) and max_latency_us (index 1); it is
// always ready and should only be written while no header is in flight.
// Per channel a start-sorted ring of RING_DEPTH headers sits in one memory
// with a single read and a single write port, one entry moved per cycle.
// Flow: a header rejected by the empty, age or future test, or the first header
// of a channel, is judged in the check state alone; otherwise the ring is scanned
// entry by entry up to the fill level (a scan rejection stops at the offending
// entry), then entries are shifted to make room and the new one is written.
// Every verdict is then handed to the output register.
// Only one header is worked on at a time; pkt_i.ready is high while idle.
// The verdict sits in an output register, so a stalled receiver holds the
// verdict there while the next header is already taken and processed.
// Reset empties every ring (fill levels to zero), restores the register
// defaults and drops any pending verdict; no clearing pass is needed.
module timestamped_packet_dedup_filter import tpdf_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int RING_DEPTH   = DEF_RING_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tpdf_pkt_if.sink   pkt_i,
  tpdf_res_if.source res_o,
  tpdf_cfg_if.sink   cfg_i
);

  localparam int DEPTH  = NUM_CHANNELS * RING_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [REG_W-1:0]  max_future_q, max_latency_q;
  logic              out_valid_q;
  result_t           out_q;
  pkt_t              pkt;
  logic              seq_valid, seq_ready;
  result_t           seq_res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  assign pkt.channel      = pkt_i.channel;
  assign pkt.start_time   = pkt_i.start_time;
  assign pkt.end_time     = pkt_i.end_time;
  assign pkt.sample_rate  = pkt_i.sample_rate;
  assign pkt.sample_count = pkt_i.sample_count;
  assign pkt.now_time     = pkt_i.now_time;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_future_q  <= MAX_FUTURE_RST;
      max_latency_q <= MAX_LATENCY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_MAX_FUTURE:  max_future_q  <= cfg_i.data;
        REG_MAX_LATENCY: max_latency_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tpdf_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .RING_DEPTH   (RING_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_valid_i   (pkt_i.valid),
    .pkt_i         (pkt),
    .pkt_ready_o   (pkt_i.ready),
    .max_future_i  (max_future_q),
    .max_latency_i (max_latency_q),
    .res_valid_o   (seq_valid),
    .res_o         (seq_res),
    .res_ready_i   (seq_ready),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  tpdf_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: take a verdict when empty or being drained
  assign seq_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_ready) begin
      out_valid_q <= seq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ready && seq_valid) out_q <= seq_res;
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.allowed = out_q.allowed;
  assign res_o.verdict = out_q.verdict;

  // The flag follows the verdict code
  a_allowed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.allowed ==
      (res_o.verdict == V_APPENDED || res_o.verdict == V_BACKFILLED)))
    else $error("allowed flag disagrees with verdict");

  // One header at a time: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready) |=> !pkt_i.ready)
    else $error("header accepted while another is in flight");

  // A verdict handed over always lands in the output register
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_valid && seq_ready) |=> res_o.valid)
    else $error("verdict lost at handover");

endmodule

### dv/tpdf_verdict_checker.sv
module tpdf_verdict_checker import tpdf_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int RING_DEPTH   = DEF_RING_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tpdf_pkt_if   pkt,
  tpdf_res_if   res,
  tpdf_cfg_if   cfg,
  output int    fail_count_o,
  output int    pending_o,
  output int    verdicts_seen_o,
  output int    stored_seen_o
);

  // Shadow copy of the rings and registers
  logic [TIME_W-1:0] ring_start [NUM_CHANNELS][RING_DEPTH];
  logic [TIME_W-1:0] ring_end   [NUM_CHANNELS][RING_DEPTH];
  logic [RATE_W-1:0] ring_rate  [NUM_CHANNELS][RING_DEPTH];
  int                ring_fill  [NUM_CHANNELS];
  logic [REG_W-1:0]  lead_limit;
  logic [REG_W-1:0]  lag_limit;
  result_t           verdict_q [$];

  // Start tolerance per rate band, zero when the rate is unclassifiable
  function automatic logic [63:0] start_window(input logic [RATE_W-1:0] rate);
    if (rate < RATE_BAND_LOW)       return 64'(TOL_LOW);
    else if (rate < RATE_BAND_MID)  return 64'(TOL_MID);
    else if (rate < RATE_BAND_HIGH) return 64'(TOL_HIGH);
    else if (rate < RATE_BAND_TOP)  return 64'(TOL_TOP);
    return 64'd0;
  endfunction

  // Drop the oldest entry of a full ring
  function automatic void evict_oldest(input int ch);
    for (int i = 0; i + 1 < RING_DEPTH; i++) begin
      ring_start[ch][i] = ring_start[ch][i+1];
      ring_end[ch][i]   = ring_end[ch][i+1];
      ring_rate[ch][i]  = ring_rate[ch][i+1];
    end
  endfunction

  // Judge one header and update the shadow rings
  function automatic verdict_e judge_header(input pkt_t p);
    int          ch;
    int          n;
    int          pos;
    logic [63:0] st, en, now, tol, d;
    ch  = int'(p.channel) % NUM_CHANNELS;
    n   = ring_fill[ch];
    st  = 64'(p.start_time);
    en  = 64'(p.end_time);
    now = 64'(p.now_time);
    tol = start_window(p.sample_rate);
    if (p.sample_count == '0) return V_EMPTY;
    if (en + 64'(lag_limit) < now) return V_EXPIRED;
    if (en > now + 64'(lead_limit)) return V_FUTURE;
    if (n == 0) begin
      if (tol == 0) return V_BAD_RATE;
      ring_start[ch][0] = p.start_time;
      ring_end[ch][0]   = p.end_time;
      ring_rate[ch][0]  = p.sample_rate;
      ring_fill[ch]     = 1;
      return V_APPENDED;
    end
    for (int i = 0; i < n; i++) begin
      if (ring_rate[ch][i] != p.sample_rate) return V_RATE_MISMATCH;
      if (tol == 0) return V_BAD_RATE;
      d = (st >= 64'(ring_start[ch][i])) ? st - 64'(ring_start[ch][i])
                                         : 64'(ring_start[ch][i]) - st;
      if (d < tol) return V_DUPLICATE;
    end
    // newer than everything: append at the top
    if (st > 64'(ring_start[ch][n-1])) begin
      if (n == RING_DEPTH) begin
        evict_oldest(ch);
        n--;
      end
      ring_start[ch][n] = p.start_time;
      ring_end[ch][n]   = p.end_time;
      ring_rate[ch][n]  = p.sample_rate;
      ring_fill[ch]     = n + 1;
      return V_APPENDED;
    end
    // older: reject on any overlap with a stored span
    for (int i = 0; i < n; i++) begin
      if ((st >= 64'(ring_start[ch][i]) && st <= 64'(ring_end[ch][i])) ||
          (en >= 64'(ring_start[ch][i]) && en <= 64'(ring_end[ch][i])))
        return V_SLIP;
    end
    if (n == RING_DEPTH) begin
      evict_oldest(ch);
      n--;
    end
    pos = 0;
    while (pos < n && 64'(ring_start[ch][pos]) < st) pos++;
    for (int i = n; i > pos; i--) begin
      ring_start[ch][i] = ring_start[ch][i-1];
      ring_end[ch][i]   = ring_end[ch][i-1];
      ring_rate[ch][i]  = ring_rate[ch][i-1];
    end
    ring_start[ch][pos] = p.start_time;
    ring_end[ch][pos]   = p.end_time;
    ring_rate[ch][pos]  = p.sample_rate;
    ring_fill[ch]       = n + 1;
    return V_BACKFILLED;
  endfunction

  // Watch the three channels, check results first, then predict new beats
  always @(posedge clk_i or negedge rst_ni) begin
    pkt_t     hdr;
    result_t  want;
    verdict_e v;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) ring_fill[c] = 0;
      lead_limit = MAX_FUTURE_RST;
      lag_limit  = MAX_LATENCY_RST;
      verdict_q.delete();
      fail_count_o    = 0;
      verdicts_seen_o = 0;
      stored_seen_o   = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat with nothing expected: allowed=%0d verdict=%0d",
                 res.allowed, res.verdict);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          verdicts_seen_o++;
          if (res.allowed) stored_seen_o++;
          if (res.allowed !== want.allowed) begin
            $error("allowed: expected %0d, actual %0d", want.allowed, res.allowed);
            fail_count_o++;
          end
          if (res.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, res.verdict);
            fail_count_o++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MAX_FUTURE) lead_limit = cfg.data;
        else lag_limit = cfg.data;
      end
      if (pkt.valid && pkt.ready) begin
        hdr = '{channel: pkt.channel, start_time: pkt.start_time, end_time: pkt.end_time,
                sample_rate: pkt.sample_rate, sample_count: pkt.sample_count,
                now_time: pkt.now_time};
        v = judge_header(hdr);
        want.verdict = v;
        want.allowed = (v == V_APPENDED || v == V_BACKFILLED);
        verdict_q.insert(verdict_q.size(), want);
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

### dv/tb_timestamped_packet_dedup_filter.sv
module tb_timestamped_packet_dedup_filter;
  import tpdf_pkg::*;

  localparam int          NCH        = DEF_NUM_CHANNELS;
  localparam int          PHASE_LEN  = 270;
  localparam longint      CYCLE_CAP  = 4000000;
  localparam logic [63:0] TIME_TOP   = 64'h1F_FFFF_FFFF_FFFF;
  localparam logic [63:0] REG_TOP    = 64'hFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tpdf_pkt_if pkt_if ();
  tpdf_res_if res_if ();
  tpdf_cfg_if cfg_if ();

  int fail_count, pending, verdicts_seen, stored_seen;
  int idle_pct, stall_pct;
  logic hold_req, hold_used;
  int hold_left;
  longint cycles;

  // Per-channel sequence generator state
  logic [63:0]       cursor    [NCH];
  logic [63:0]       last_st   [NCH];
  logic [RATE_W-1:0] chan_rate [NCH];
  logic [63:0]       hole_lo   [NCH];
  logic [63:0]       hole_hi   [NCH];
  logic              hole_ok   [NCH];
  logic [63:0]       lead_cfg, lag_cfg;

  timestamped_packet_dedup_filter u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  tpdf_verdict_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pkt            (pkt_if),
    .res            (res_if),
    .cfg            (cfg_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .verdicts_seen_o(verdicts_seen),
    .stored_seen_o  (stored_seen)
  );

  always #10 clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_used    <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used    <= 1'b1;
      hold_left    <= 800;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic pkt_t mk(input int ch, input logic [63:0] st, input logic [63:0] en,
                              input int rate, input int cnt, input logic [63:0] now);
    pkt_t p;
    p.channel      = CH_W'(ch);
    p.start_time   = TIME_W'(st);
    p.end_time     = TIME_W'(en);
    p.sample_rate  = RATE_W'(rate);
    p.sample_count = CNT_W'(cnt);
    p.now_time     = TIME_W'(now);
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one header, with a random gap in front of it
  task automatic send_pkt(input pkt_t p);
    if ($urandom_range(99) < idle_pct) begin
      pkt_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    pkt_if.valid        <= 1'b1;
    pkt_if.channel      <= p.channel;
    pkt_if.start_time   <= p.start_time;
    pkt_if.end_time     <= p.end_time;
    pkt_if.sample_rate  <= p.sample_rate;
    pkt_if.sample_count <= p.sample_count;
    pkt_if.now_time     <= p.now_time;
    do @(posedge clk_i); while (!pkt_if.ready);
  endtask

  // Drain all verdicts, then write one register
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    pkt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (5) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= REG_W'(val);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MAX_FUTURE) lead_cfg = val & REG_TOP;
    else lag_cfg = val & REG_TOP;
  endtask

  // Current time that passes the age and future tests
  function automatic logic [63:0] pick_now(input logic [63:0] en);
    logic [63:0] lag, lead;
    lag  = (lag_cfg  < 64'd1000000) ? lag_cfg  : 64'd1000000;
    lead = (lead_cfg < 64'd1000000) ? lead_cfg : 64'd1000000;
    if (lead != 0 && $urandom_range(1) == 1) return en - 64'($urandom_range(32'(lead)));
    return en + 64'($urandom_range(32'(lag)));
  endfunction

  // One random header: mostly well-formed sequences, some broken ones and noise
  function automatic pkt_t next_pkt();
    int           ch, kind, rate, cnt;
    logic [63:0]  st, en, dur, gap, tol;
    logic [223:0] noise;
    ch   = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(NCH - 1);
    kind = $urandom_range(99);
    rate = chan_rate[ch];
    cnt  = $urandom_range(65535, 1);
    tol  = (rate < 105) ? 15000 : (rate < 255) ? 4500 : (rate < 505) ? 2500 : 1500;
    if (kind < 8) begin
      noise = {$urandom(), rand64(), rand64(), rand64()};
      return pkt_t'(noise[$bits(pkt_t)-1:0]);
    end else if (kind < 11) begin
      st = cursor[ch];
      en = st + 1000;
      return mk(ch, st, en, rate, 0, pick_now(en));
    end else if (kind < 15) begin
      st = cursor[ch] + 100000;
      en = st + 1000;
      return mk(ch, st, en, rate ^ (1 << $urandom_range(9)), cnt, pick_now(en));
    end else if (kind < 24) begin
      st = last_st[ch] + tol - 64'($urandom_range(2 * 32'(tol) - 1));
      en = st + 500;
      return mk(ch, st, en, rate, cnt, pick_now(en));
    end else if (kind < 30) begin
      st = last_st[ch] - 30000;
      en = last_st[ch] + 10;
      return mk(ch, st, en, rate, cnt, pick_now(en));
    end else if (kind < 45 && hole_ok[ch]) begin
      hole_ok[ch] = 1'b0;
      st = hole_lo[ch] + 20000;
      en = st + (hole_hi[ch] - hole_lo[ch]) / 4;
      return mk(ch, st, en, rate, cnt, pick_now(en));
    end
    // in-order append, sometimes leaving a hole behind
    dur = 64'($urandom_range(200000, 1000));
    st  = cursor[ch];
    en  = st + dur;
    if ($urandom_range(99) < 30) begin
      gap = 3 * dur + 100000;
      hole_lo[ch] = en + 1;
      hole_hi[ch] = en + gap - 1;
      hole_ok[ch] = 1'b1;
    end else begin
      gap = 64'($urandom_range(40000, 20000));
    end
    cursor[ch]  = en + gap;
    last_st[ch] = st;
    return mk(ch, st, en, rate, cnt, pick_now(en));
  endfunction

  // Stimulus
  initial begin
    logic [63:0] t0;
    pkt_if.valid        <= 1'b0;
    pkt_if.channel      <= '0;
    pkt_if.start_time   <= '0;
    pkt_if.end_time     <= '0;
    pkt_if.sample_rate  <= '0;
    pkt_if.sample_count <= '0;
    pkt_if.now_time     <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_MAX_FUTURE;
    cfg_if.data         <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    cycles    = 0;
    lead_cfg  = 64'(MAX_FUTURE_RST);
    lag_cfg   = 64'(MAX_LATENCY_RST);
    for (int c = 0; c < NCH; c++) begin
      cursor[c]    = 64'h0010_0000_0000_0000 + 64'($urandom()) * 1024;
      last_st[c]   = cursor[c];
      chan_rate[c] = RATE_W'(($urandom_range(99) < 6) ? $urandom_range(1023, 1005)
                                                      : $urandom_range(1004));
      hole_ok[c]   = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejections, band edges, backfill, slip, field extremes
    t0 = 64'd1000000000000;
    send_pkt(mk(8, t0, t0 + 100, 50, 10, t0 + 100));
    send_pkt(mk(8, t0, t0 + 100, 50, 0, t0 + 100));
    send_pkt(mk(8, t0, t0 + 100, 50, 1, t0 + 100 + 500000001));
    send_pkt(mk(8, t0, t0 + 100, 50, 1, t0 + 99));
    send_pkt(mk(8, t0 + 14999, t0 + 15050, 50, 1, t0 + 15050));
    send_pkt(mk(8, t0 + 15000, t0 + 15100, 50, 1, t0 + 15100));
    send_pkt(mk(8, t0 + 100000, t0 + 100100, 51, 1, t0 + 100100));
    send_pkt(mk(9, t0, t0 + 10, 1005, 1, t0 + 10));
    send_pkt(mk(9, t0, t0 + 10, 1023, 1, t0 + 10));
    send_pkt(mk(10, t0, t0 + 10, 1004, 1, t0 + 10));
    send_pkt(mk(10, t0 + 1499, t0 + 1510, 1004, 1, t0 + 1510));
    send_pkt(mk(10, t0 + 1500, t0 + 1510, 1004, 1, t0 + 1510));
    send_pkt(mk(8, t0 - 100000, t0 - 90000, 50, 1, t0));
    send_pkt(mk(8, t0 - 50000, t0 + 50, 50, 1, t0 + 100));
    send_pkt(mk(8, t0 - 30000, t0 - 200000, 50, 1, t0));
    send_pkt(mk(11, TIME_TOP, TIME_TOP, 0, 65535, TIME_TOP));
    send_pkt(mk(12, 0, 0, 104, 1, 0));
    send_pkt(mk(12, 4499, 4600, 104, 1, 4600));
    send_pkt(mk(13, 0, 0, 0, 1, TIME_TOP));
    send_pkt(mk(13, 0, TIME_TOP, 0, 1, 0));

    // Random phases, each under its own register setting and idling mix
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1;
        end
        1: begin
          write_reg(REG_MAX_FUTURE, 0);
          write_reg(REG_MAX_LATENCY, 0);
          idle_pct = 71; stall_pct = 0;
        end
        2: begin
          write_reg(REG_MAX_FUTURE, REG_TOP);
          write_reg(REG_MAX_LATENCY, REG_TOP);
          idle_pct = 0;  stall_pct = 71;
        end
        3: begin
          write_reg(REG_MAX_FUTURE, 64'($urandom_range(5000000)));
          write_reg(REG_MAX_LATENCY, 64'($urandom_range(5000000)));
          idle_pct = 16; stall_pct = 16;
        end
        default: begin
          write_reg(REG_MAX_FUTURE, 1000000);
          write_reg(REG_MAX_LATENCY, 64'd1000000000);
          idle_pct = 0;  stall_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_LEN; k++) send_pkt(next_pkt());
    end

    // Drain and give the verdict
    pkt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (150) @(posedge clk_i);
    $display("Checked %0d verdicts (%0d headers stored) over five register settings,",
             verdicts_seen, stored_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/tpdf_pkg.sv
rtl/core/tpdf_if.sv
rtl/core/tpdf_mem.sv
rtl/core/tpdf_seq.sv
rtl/core/timestamped_packet_dedup_filter.sv
dv/tpdf_verdict_checker.sv
dv/tb_timestamped_packet_dedup_filter.sv
